// File: src/interp_curve_lookup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker of the curve lookup block.
// ----------------------------------------------------------------------------
`ifndef INTERP_CURVE_LOOKUP_MACROS_SVH
`define INTERP_CURVE_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ICL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("curve lookup check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ICL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("curve lookup check failed");

`endif

// File: src/icl_pkg.sv
// ----------------------------------------------------------------------------
// icl_pkg
// Shared codes and the sequencer state type of the curve lookup block.
// ----------------------------------------------------------------------------
package icl_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_INV  = 2'd2;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_CURVE_MODE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_LASTW, S_LAST, S_FIRSTW, S_FIRST, S_WALKW, S_WALK, S_DIVGO,
    S_DIVW, S_BIS, S_M1, S_M2, S_M3, S_BL, S_BL2, S_FIN
  } state_t;

endpackage

// File: src/icl_mul.sv
// ----------------------------------------------------------------------------
// icl_mul
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module icl_mul #(
  parameter int AW = 33,
  parameter int BW = 17
) (
  input  logic                  clk,
  input  logic signed [AW-1:0]  a,
  input  logic        [BW-1:0]  b,
  output logic signed [AW+BW:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

endmodule

// File: src/icl_div.sv
// ----------------------------------------------------------------------------
// icl_div
// Restoring divider, one quotient bit per cycle, result capped at one.
// ----------------------------------------------------------------------------
module icl_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [32:0]        num,
  input  logic [32:0]        den,
  output logic               done,
  output logic [FRAC_BITS:0] quot
);

  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [34:0]   rem;
  logic [34:0]   den_x;
  logic          qbit;
  logic [34:0]   rem_sub;
  logic [FRAC_BITS:0] q_next;

  assign den_x   = {2'b00, den};
  assign qbit    = (rem >= den_x);
  assign rem_sub = qbit ? (rem - den_x) : rem;
  assign q_next  = {quot[FRAC_BITS-1:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == 33'd0) begin
          quot <= '0;
          done <= 1'b1;
        end else if ({1'b0, num} >= {den, 1'b0}) begin
          // Offset at least twice the width: the fraction saturates.
          quot <= ONE;
          done <= 1'b1;
        end else begin
          rem  <= {2'b00, num};
          quot <= '0;
          cnt  <= CW'(FRAC_BITS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_sub << 1;
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= (q_next > ONE) ? ONE : q_next;
        end else begin
          quot <= q_next;
        end
      end
    end
  end

endmodule

// File: src/interp_curve_lookup.sv
// ----------------------------------------------------------------------------
// interp_curve_lookup
// Piecewise linear or smoothstep calibration curve with inverse lookup.
// ----------------------------------------------------------------------------
// Input transactions carry a mode: a load writes one point (no result),
// a forward lookup maps x to y and an inverse lookup maps y to x, each
// giving one result on the output channel. Points go in ascending x.
// The user must write point_count and curve_mode on the cfg port only
// while idle; the block does not enforce it. A load does not stall the
// input. A lookup walks the table through the point memory's single read
// port, then runs the shared divider and the shared multiplier; forward
// smoothstep adds a polynomial step and inverse smoothstep a bisection.
// in_stall stays high until the result enters the output register. A
// clamped lookup ends once the last and first points are read, a flat
// segment skips the divider and the multiplier, and a lookup on an empty
// table goes straight to the result. The result is held in an output
// register; a lookup that finishes while the previous result is still
// stalled waits for it. Reset clears the sequencer, the configuration
// registers and the output valid; the point memory keeps its contents.
// ----------------------------------------------------------------------------
module interp_curve_lookup #(
  parameter int MAX_POINTS   = 16,
  parameter int FRAC_BITS    = 16,
  parameter int BISECT_STEPS = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic [3:0]                point_slot,
  input  logic signed [31:0]        point_abscissa,
  input  logic signed [31:0]        point_ordinate,
  input  logic signed [31:0]        query_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        answer_value,
  output logic                      was_clamped,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [icl_pkg::CFG_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int BC_W  = $clog2(BISECT_STEPS + 1);
  localparam int FW    = FRAC_BITS + 1;
  localparam int PRW   = 33 + FW + 1;
  localparam logic [FRAC_BITS:0] ONE = FW'(1) << FRAC_BITS;

  icl_pkg::state_t state, state_next;

  logic [4:0] point_count;
  logic       curve_mode;

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic signed [31:0] rd_x, rd_y;

  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   n;
  logic               inv;
  logic signed [31:0] q;
  logic signed [31:0] x0, y0, xl, yl;
  logic [32:0]        dnum, dden;
  logic [FRAC_BITS:0] tgt, u, w, t2, lo, hi;
  logic [BC_W-1:0]    bcnt;
  logic signed [31:0] ans;
  logic               clamp;

  logic               accept;
  logic               div_start, div_done;
  logic [FRAC_BITS:0] div_quot;
  logic signed [32:0] mul_a;
  logic [FRAC_BITS:0] mul_b;
  logic signed [PRW-1:0] prod;

  // Combinational helpers
  logic signed [31:0] rd_key, rd_oth, key0, last_key, last_oth;
  logic               lo_clamp, hi_clamp, hit, flat, last_idx, out_free;
  logic signed [32:0] off, wid;
  logic [FRAC_BITS:0] prod_frac, mid, poly;
  logic [FRAC_BITS+2:0] poly_raw;
  logic [FRAC_BITS+1:0] lohi;
  logic signed [31:0] p0, p1;
  logic signed [PRW-1:0] prod_sh;
  logic signed [34:0] blend_sum;
  logic signed [31:0] blend_sat;
  logic [CNT_W-1:0]   n_in;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign n_in = (int'(point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                 : CNT_W'(point_count);

  assign rd_key   = inv ? rd_y : rd_x;
  assign rd_oth   = inv ? rd_x : rd_y;
  assign key0     = inv ? y0 : x0;
  assign last_key = inv ? yl : xl;
  assign last_oth = inv ? xl : yl;
  assign lo_clamp = (q <= rd_key);
  assign hi_clamp = (q >= last_key);
  assign hit      = inv ? ((q >= y0 && q <= rd_y) || (q <= y0 && q >= rd_y))
                        : (q < rd_x);
  assign flat     = (rd_key == key0);
  assign last_idx = (CNT_W'(idx) == n - CNT_W'(1));
  assign off      = $signed({q[31], q}) - $signed({key0[31], key0});
  assign wid      = $signed({rd_key[31], rd_key}) - $signed({key0[31], key0});

  assign prod_frac = prod[2*FRAC_BITS:FRAC_BITS];
  assign lohi      = {1'b0, lo} + {1'b0, hi};
  assign mid       = lohi[FRAC_BITS+1:1];
  assign poly_raw  = ({2'b00, t2} << 1) + {2'b00, t2} - ({2'b00, prod_frac} << 1);
  assign poly      = (poly_raw > {2'b00, ONE}) ? ONE : poly_raw[FRAC_BITS:0];

  assign p0        = inv ? x0 : y0;
  assign p1        = inv ? xl : yl;
  assign prod_sh   = prod >>> FRAC_BITS;
  assign blend_sum = {{3{p0[31]}}, p0} + prod_sh[34:0];
  always_comb begin
    if (blend_sum > 35'sh0_7FFF_FFFF) blend_sat = 32'sh7FFF_FFFF;
    else if (blend_sum < -35'sh0_8000_0000) blend_sat = -32'sh8000_0000;
    else blend_sat = blend_sum[31:0];
  end

  icl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .done(div_done), .quot(div_quot)
  );

  icl_mul #(.AW(33), .BW(FW)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
  );

  // Point memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && mode == icl_pkg::MODE_LOAD && int'(point_slot) < MAX_POINTS) begin
      mem_x[IDX_W'(point_slot)] <= point_abscissa;
      mem_y[IDX_W'(point_slot)] <= point_ordinate;
    end
    rd_x <= mem_x[idx];
    rd_y <= mem_y[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      curve_mode  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        icl_pkg::CFG_POINT_COUNT: point_count <= cfg_data;
        icl_pkg::CFG_CURVE_MODE:  curve_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      icl_pkg::S_IDLE: begin
        if (accept && (mode == icl_pkg::MODE_FWD || mode == icl_pkg::MODE_INV))
          state_next = (n_in == '0) ? icl_pkg::S_FIN : icl_pkg::S_LASTW;
      end
      icl_pkg::S_LASTW:  state_next = icl_pkg::S_LAST;
      icl_pkg::S_LAST:   state_next = icl_pkg::S_FIRSTW;
      icl_pkg::S_FIRSTW: state_next = icl_pkg::S_FIRST;
      icl_pkg::S_FIRST:
        state_next = (lo_clamp || hi_clamp) ? icl_pkg::S_FIN : icl_pkg::S_WALKW;
      icl_pkg::S_WALKW:  state_next = icl_pkg::S_WALK;
      icl_pkg::S_WALK: begin
        if (hit) state_next = flat ? icl_pkg::S_FIN : icl_pkg::S_DIVGO;
        else     state_next = last_idx ? icl_pkg::S_FIN : icl_pkg::S_WALKW;
      end
      icl_pkg::S_DIVGO:  state_next = icl_pkg::S_DIVW;
      icl_pkg::S_DIVW: begin
        if (div_done) begin
          if (!curve_mode) state_next = icl_pkg::S_BL;
          else if (!inv)   state_next = icl_pkg::S_M1;
          else             state_next = icl_pkg::S_BIS;
        end
      end
      icl_pkg::S_BIS:
        state_next = (bcnt == BC_W'(BISECT_STEPS)) ? icl_pkg::S_BL : icl_pkg::S_M1;
      icl_pkg::S_M1:     state_next = icl_pkg::S_M2;
      icl_pkg::S_M2:     state_next = icl_pkg::S_M3;
      icl_pkg::S_M3:     state_next = inv ? icl_pkg::S_BIS : icl_pkg::S_BL;
      icl_pkg::S_BL:     state_next = icl_pkg::S_BL2;
      icl_pkg::S_BL2:    state_next = icl_pkg::S_FIN;
      icl_pkg::S_FIN:    if (out_free) state_next = icl_pkg::S_IDLE;
      default:           state_next = icl_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = (state != icl_pkg::S_IDLE);
    div_start = (state == icl_pkg::S_DIVGO);
    mul_a     = $signed(33'(u));
    mul_b     = u;
    case (state)
      icl_pkg::S_M2: begin
        mul_a = $signed(33'(prod_frac));
        mul_b = u;
      end
      icl_pkg::S_BL: begin
        mul_a = $signed({p1[31], p1}) - $signed({p0[31], p0});
        mul_b = w;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= icl_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      icl_pkg::S_IDLE: begin
        q     <= query_value;
        inv   <= (mode == icl_pkg::MODE_INV);
        n     <= n_in;
        idx   <= IDX_W'(n_in - CNT_W'(1));
        ans   <= '0;
        clamp <= 1'b1;
      end
      icl_pkg::S_LAST: begin
        xl  <= rd_x;
        yl  <= rd_y;
        idx <= '0;
      end
      icl_pkg::S_FIRST: begin
        x0    <= rd_x;
        y0    <= rd_y;
        clamp <= 1'b1;
        if (lo_clamp)      ans <= rd_oth;
        else if (hi_clamp) ans <= last_oth;
        idx <= IDX_W'(1);
      end
      icl_pkg::S_WALK: begin
        if (hit) begin
          // A zero-width or flat segment answers its first point.
          ans   <= inv ? x0 : y0;
          clamp <= 1'b0;
          xl    <= rd_x;
          yl    <= rd_y;
          dnum  <= off[32] ? 33'(-off) : 33'(off);
          dden  <= wid[32] ? 33'(-wid) : 33'(wid);
        end else begin
          x0  <= rd_x;
          y0  <= rd_y;
          ans <= last_oth;
          idx <= idx + IDX_W'(1);
        end
      end
      icl_pkg::S_DIVW: begin
        if (div_done) begin
          tgt  <= div_quot;
          w    <= div_quot;
          u    <= div_quot;
          lo   <= '0;
          hi   <= ONE;
          bcnt <= '0;
        end
      end
      icl_pkg::S_BIS: begin
        w <= mid;
        u <= mid;
      end
      icl_pkg::S_M2: t2 <= prod_frac;
      icl_pkg::S_M3: begin
        w <= poly;
        if (poly < tgt) lo <= u;
        else            hi <= u;
        bcnt <= bcnt + BC_W'(1);
      end
      icl_pkg::S_BL2: ans <= blend_sat;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == icl_pkg::S_FIN && out_free) begin
      out_valid    <= 1'b1;
      answer_value <= ans;
      was_clamped  <= clamp;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: src/icl_checker.sv
// ----------------------------------------------------------------------------
// icl_checker
// Port-level checks of the curve lookup block, bound to its top level.
// ----------------------------------------------------------------------------
`include "interp_curve_lookup_macros.svh"

module icl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] answer_value,
  input logic        was_clamped
);

  logic        lookup_accept;
  logic [32:0] result_bits;

  assign lookup_accept = in_valid && !in_stall &&
                         (mode == icl_pkg::MODE_FWD || mode == icl_pkg::MODE_INV);
  assign result_bits   = {was_clamped, answer_value};

  // A lookup keeps the input side busy on the following cycle.
  `ICL_ASSERT_NEXT(lookup_busy, lookup_accept, in_stall)

  // A new result only appears after work with the input stalled.
  `ICL_ASSERT_NOW(result_from_work, $rose(out_valid), $past(in_stall))

  // A stalled result holds.
  `ICL_ASSERT_NEXT(result_holds, out_valid && out_stall, out_valid && $stable(result_bits))

  // Nothing is offered right after reset.
  `ICL_ASSERT_NOW(clean_after_reset, $past(rst), !out_valid)

endmodule

bind interp_curve_lookup icl_checker u_icl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
  .out_valid(out_valid), .out_stall(out_stall), .answer_value(answer_value),
  .was_clamped(was_clamped)
);
